@@ hdl/ffpa_pkg.sv @@
package ffpa_pkg;

    localparam int MAX_PARTITIONS = 16;
    localparam int IDX_W  = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);
    localparam int KB_W   = 16;
    localparam int STEP_W = 4;

    localparam logic [KB_W-1:0] AVAILABLE_KB_RESET = 16'd3072;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EXCEEDS  = 3'd1;
    localparam logic [2:0] ST_ALL_USED = 3'd2;
    localparam logic [2:0] ST_TOO_BIG  = 3'd3;
    localparam logic [2:0] ST_CLOSED   = 3'd4;

    // datapath operations
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_GRANT = 2'd2;
    localparam logic [1:0] OP_CLOSE = 2'd3;

    // jump conditions
    localparam logic [3:0] C_NEVER       = 4'd0;
    localparam logic [3:0] C_NO_IN       = 4'd1;
    localparam logic [3:0] C_IS_ALLOC    = 4'd2;
    localparam logic [3:0] C_CLOSED_FULL = 4'd3;
    localparam logic [3:0] C_TOO_BIG     = 4'd4;
    localparam logic [3:0] C_NONE_FREE   = 4'd5;
    localparam logic [3:0] C_SCAN_END    = 4'd6;
    localparam logic [3:0] C_FIT         = 4'd7;
    localparam logic [3:0] C_OUT_BUSY    = 4'd8;

    // microprogram steps
    localparam logic [STEP_W-1:0] S_FETCH      = 4'd0;
    localparam logic [STEP_W-1:0] S_DISPATCH   = 4'd1;
    localparam logic [STEP_W-1:0] S_LOAD_CHK   = 4'd2;
    localparam logic [STEP_W-1:0] S_LOAD       = 4'd3;
    localparam logic [STEP_W-1:0] S_ALLOC      = 4'd5;
    localparam logic [STEP_W-1:0] S_SCAN       = 4'd6;
    localparam logic [STEP_W-1:0] S_GRANT      = 4'd7;
    localparam logic [STEP_W-1:0] S_EMIT_CLOSE = 4'd8;
    localparam logic [STEP_W-1:0] S_EMIT_EXCD  = 4'd9;
    localparam logic [STEP_W-1:0] S_EMIT_OK    = 4'd10;
    localparam logic [STEP_W-1:0] S_EMIT_USED  = 4'd11;
    localparam logic [STEP_W-1:0] S_EMIT_BIG   = 4'd12;

    typedef struct packed {
        logic              ready;
        logic              emit;
        logic [2:0]        st;
        logic [1:0]        op;
        logic              clr_idx;
        logic              inc_idx;
        logic [3:0]        jc0;
        logic [STEP_W-1:0] jt0;
        logic [3:0]        jc1;
        logic [STEP_W-1:0] jt1;
        logic [STEP_W-1:0] nxt;
    } ctrl_t;

    typedef struct packed {
        logic no_in;
        logic is_alloc;
        logic closed_full;
        logic too_big;
        logic none_free;
        logic scan_end;
        logic fit;
        logic out_busy;
    } flags_t;

    // Actions of a step run only when neither jump is taken.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '0;
        w.nxt = S_FETCH;
        case (step)
            S_FETCH:
            begin
                w.ready = 1'b1;
                w.jc0   = C_NO_IN;
                w.jt0   = S_FETCH;
                w.nxt   = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                w.jc0 = C_IS_ALLOC;
                w.jt0 = S_ALLOC;
                w.nxt = S_LOAD_CHK;
            end
            S_LOAD_CHK:
            begin
                w.jc0 = C_CLOSED_FULL;
                w.jt0 = S_EMIT_CLOSE;
                w.jc1 = C_TOO_BIG;
                w.jt1 = S_EMIT_EXCD;
                w.nxt = S_LOAD;
            end
            S_LOAD:
            begin
                w.op  = OP_LOAD;
                w.nxt = S_EMIT_OK;
            end
            S_ALLOC:
            begin
                w.jc0     = C_NONE_FREE;
                w.jt0     = S_EMIT_USED;
                w.clr_idx = 1'b1;
                w.nxt     = S_SCAN;
            end
            S_SCAN:
            begin
                w.jc0     = C_SCAN_END;
                w.jt0     = S_EMIT_BIG;
                w.jc1     = C_FIT;
                w.jt1     = S_GRANT;
                w.inc_idx = 1'b1;
                w.nxt     = S_SCAN;
            end
            S_GRANT:
            begin
                w.op  = OP_GRANT;
                w.nxt = S_EMIT_OK;
            end
            S_EMIT_CLOSE:
            begin
                w.emit = 1'b1;
                w.st   = ST_CLOSED;
                w.jc0  = C_OUT_BUSY;
                w.jt0  = S_EMIT_CLOSE;
            end
            S_EMIT_EXCD:
            begin
                w.emit = 1'b1;
                w.st   = ST_EXCEEDS;
                w.op   = OP_CLOSE;
                w.jc0  = C_OUT_BUSY;
                w.jt0  = S_EMIT_EXCD;
            end
            S_EMIT_OK:
            begin
                w.emit = 1'b1;
                w.st   = ST_OK;
                w.jc0  = C_OUT_BUSY;
                w.jt0  = S_EMIT_OK;
            end
            S_EMIT_USED:
            begin
                w.emit = 1'b1;
                w.st   = ST_ALL_USED;
                w.jc0  = C_OUT_BUSY;
                w.jt0  = S_EMIT_USED;
            end
            S_EMIT_BIG:
            begin
                w.emit = 1'b1;
                w.st   = ST_TOO_BIG;
                w.jc0  = C_OUT_BUSY;
                w.jt0  = S_EMIT_BIG;
            end
            default:
            begin
                w.nxt = S_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hdl/ffpa_sequencer.sv @@
module ffpa_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  ffpa_pkg::flags_t flags,
    output ffpa_pkg::ctrl_t  ctrl,
    output logic            exec
);

    logic [ffpa_pkg::STEP_W-1:0] step_reg;
    logic [ffpa_pkg::STEP_W-1:0] step_next;
    logic                        take0;
    logic                        take1;

    function automatic logic cond_sel(input logic [3:0] c, input ffpa_pkg::flags_t f);
        logic r;
        case (c)
            ffpa_pkg::C_NEVER:       r = 1'b0;
            ffpa_pkg::C_NO_IN:       r = f.no_in;
            ffpa_pkg::C_IS_ALLOC:    r = f.is_alloc;
            ffpa_pkg::C_CLOSED_FULL: r = f.closed_full;
            ffpa_pkg::C_TOO_BIG:     r = f.too_big;
            ffpa_pkg::C_NONE_FREE:   r = f.none_free;
            ffpa_pkg::C_SCAN_END:    r = f.scan_end;
            ffpa_pkg::C_FIT:         r = f.fit;
            ffpa_pkg::C_OUT_BUSY:    r = f.out_busy;
            default:                 r = 1'b0;
        endcase
        return r;
    endfunction

    assign ctrl  = ffpa_pkg::ucode(step_reg);
    assign take0 = cond_sel(ctrl.jc0, flags);
    assign take1 = cond_sel(ctrl.jc1, flags);
    assign exec  = !take0 && !take1;

    always_comb
    begin
        if (take0)
        begin
            step_next = ctrl.jt0;
        end
        else if (take1)
        begin
            step_next = ctrl.jt1;
        end
        else
        begin
            step_next = ctrl.nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ffpa_pkg::S_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ hdl/ffpa_datapath.sv @@
module ffpa_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ffpa_pkg::ctrl_t           ctrl,
    input  logic                      exec,
    input  logic                      s_tvalid,
    input  logic                      s_tuser,
    input  logic [ffpa_pkg::KB_W-1:0] s_tdata,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [23:0]               m_tdata,
    input  logic                      available_kb_we,
    input  logic [ffpa_pkg::KB_W-1:0] available_kb_wdata,
    output ffpa_pkg::flags_t          flags
);

    localparam int N = ffpa_pkg::MAX_PARTITIONS;

    logic                            req_alloc_reg;
    logic [ffpa_pkg::KB_W-1:0]       req_size_reg;
    logic [ffpa_pkg::KB_W-1:0]       part_size_mem [N];
    logic [ffpa_pkg::KB_W-1:0]       part_rd_reg;
    logic [N-1:0]                    part_used_reg;
    logic [ffpa_pkg::CNT_W-1:0]      part_count_reg;
    logic [ffpa_pkg::CNT_W-1:0]      used_count_reg;
    logic [ffpa_pkg::KB_W-1:0]       left_kb_reg;
    logic                            closed_reg;
    logic [ffpa_pkg::CNT_W-1:0]      idx_reg;
    logic [ffpa_pkg::CNT_W-1:0]      idx_next;
    logic [ffpa_pkg::IDX_W-1:0]      res_idx_reg;
    logic                            m_tvalid_reg;
    logic [23:0]                     m_tdata_reg;
    logic [ffpa_pkg::IDX_W-1:0]      scan_addr;
    logic [ffpa_pkg::IDX_W-1:0]      rd_addr;
    logic [ffpa_pkg::IDX_W-1:0]      load_addr;
    logic [3:0]                      out_idx;
    logic                            do_load;
    logic                            do_grant;

    assign scan_addr = idx_reg[ffpa_pkg::IDX_W-1:0];
    assign rd_addr   = idx_next[ffpa_pkg::IDX_W-1:0];
    assign load_addr = part_count_reg[ffpa_pkg::IDX_W-1:0];
    assign do_load   = exec && (ctrl.op == ffpa_pkg::OP_LOAD);
    assign do_grant  = exec && (ctrl.op == ffpa_pkg::OP_GRANT);

    assign flags.no_in       = !s_tvalid;
    assign flags.is_alloc    = req_alloc_reg;
    assign flags.closed_full = closed_reg || (part_count_reg == ffpa_pkg::CNT_W'(N));
    assign flags.too_big     = req_size_reg > left_kb_reg;
    assign flags.none_free   = used_count_reg >= part_count_reg;
    assign flags.scan_end    = idx_reg == part_count_reg;
    assign flags.fit         = !part_used_reg[scan_addr] && (req_size_reg <= part_rd_reg);
    assign flags.out_busy    = m_tvalid_reg && !m_tready;

    assign out_idx  = (ctrl.st == ffpa_pkg::ST_OK) ? 4'(res_idx_reg) : 4'd0;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // request latch on the input transfer
    always_ff @(posedge clk)
    begin
        if (exec && ctrl.ready)
        begin
            req_alloc_reg <= s_tuser;
            req_size_reg  <= s_tdata;
        end
    end

    // size read is fetched at the address the scan index moves to
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            part_size_mem[load_addr] <= req_size_reg;
        end
        part_rd_reg <= part_size_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            res_idx_reg <= load_addr;
        end
        else if (do_grant)
        begin
            res_idx_reg <= scan_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_used_reg  <= '0;
            part_count_reg <= '0;
            used_count_reg <= '0;
            left_kb_reg    <= ffpa_pkg::AVAILABLE_KB_RESET;
            closed_reg     <= 1'b0;
        end
        else
        begin
            if (do_load)
            begin
                part_count_reg <= part_count_reg + 1'b1;
                left_kb_reg    <= left_kb_reg - req_size_reg;
            end
            else if (available_kb_we && (part_count_reg == '0) && !closed_reg)
            begin
                left_kb_reg <= available_kb_wdata;
            end
            if (do_grant)
            begin
                part_used_reg[scan_addr] <= 1'b1;
                used_count_reg           <= used_count_reg + 1'b1;
            end
            if (exec && (ctrl.op == ffpa_pkg::OP_CLOSE))
            begin
                closed_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        if (exec && ctrl.clr_idx)
        begin
            idx_next = '0;
        end
        else if (exec && ctrl.inc_idx)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (exec && ctrl.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec && ctrl.emit)
        begin
            m_tdata_reg <= {1'b0, left_kb_reg, out_idx, ctrl.st};
        end
    end

endmodule

@@ hdl/first_fit_partition_allocator_unit.sv @@
// First-fit fixed-partition allocator. A load request (tuser 0) appends a
// partition of size tdata kB while a table slot is free and the unpartitioned
// memory covers it; a load that does not fit is refused and closes loading.
// An allocate request (tuser 1) takes the first unused partition, in load
// order, that is large enough. One request is handled at a time by a small
// microcoded sequencer. A load passes the fetch, dispatch, load check, load
// and emit steps (a refused load skips the load step); an allocate with
// nothing free goes from its allocate step straight to an emit step, else
// it scans the loaded partitions in order, examining one table entry per
// cycle, and ends with the grant and emit steps or, when none fits, with
// an emit step. The available_kb register starts at 3072 and reloads the
// remaining memory only while no partition is loaded and loading is open.
module first_fit_partition_allocator_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic                      s_tuser,   // [0] req_type
    input  logic [ffpa_pkg::KB_W-1:0] s_tdata,   // [15:0] size_kb
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,   // [2:0] status, [6:3] partition_index,
                                                 // [22:7] remaining_kb, [23] zero
    input  logic                      available_kb_we,
    input  logic [ffpa_pkg::KB_W-1:0] available_kb_wdata
);

    ffpa_pkg::ctrl_t  ctrl;
    ffpa_pkg::flags_t flags;
    logic             exec;

    assign s_tready = ctrl.ready;

    ffpa_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .exec  (exec)
    );

    ffpa_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctrl               (ctrl),
        .exec               (exec),
        .s_tvalid           (s_tvalid),
        .s_tuser            (s_tuser),
        .s_tdata            (s_tdata),
        .m_tready           (m_tready),
        .m_tvalid           (m_tvalid),
        .m_tdata            (m_tdata),
        .available_kb_we    (available_kb_we),
        .available_kb_wdata (available_kb_wdata),
        .flags              (flags)
    );

endmodule

@@ hdl/ffpa_checker.sv @@
module ffpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight: no transfer in the cycle after one
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken back to back");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= ffpa_pkg::ST_CLOSED) && !m_tdata[23])
        else $error("bad status code or pad bit");

    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != ffpa_pkg::ST_OK) |-> m_tdata[6:3] == 4'd0)
        else $error("index set on failed request");

endmodule

bind first_fit_partition_allocator_unit ffpa_checker u_ffpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
